[hdl/vrl_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// vrl_pkg
// shared types, constants and arithmetic step functions for the vector
// length and rescale core
// ---------------------------------------------------------------------------
package vrl_pkg;

  localparam int SQ_STAGES  = 32;  // one root bit per stage
  localparam int DIV_STAGES = 32;  // one quotient bit per stage
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;

  localparam logic [15:0] NEAR_ZERO_RST = 16'd16;
  localparam logic [31:0] POS_MAX       = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MAX       = 32'h8000_0000;

  // accepted input beat
  typedef struct packed {
    logic        op;
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] tgt;
  } item_t;

  // classified job handed from front to back
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] tgt;
    logic [31:0] len;
    logic        scale;
    logic        ok;
  } job_t;

  // square root iteration state
  typedef struct packed {
    logic [63:0] v;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  // division iteration state
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] rem;
    logic [31:0] q;
  } dv_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // one digit-by-digit root step
  function automatic sq_t sq_step(input sq_t s);
    sq_t         r;
    logic [35:0] rem2;
    logic [35:0] trial;
    rem2  = {s.rem, s.v[63:62]};
    trial = {2'b00, s.root, 2'b01};
    if (rem2 >= trial) begin
      rem2   = rem2 - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.root = {s.root[30:0], 1'b0};
    end
    r.rem = rem2[33:0];
    r.v   = {s.v[61:0], 2'b00};
    return r;
  endfunction

  // one restoring division step
  function automatic dv_t dv_step(input dv_t s, input logic [31:0] d);
    dv_t         r;
    logic [32:0] r2;
    r2 = {s.rem, s.lo[31]};
    if (r2 >= {1'b0, d}) begin
      r2  = r2 - {1'b0, d};
      r.q = {s.q[30:0], 1'b1};
    end else begin
      r.q = {s.q[30:0], 1'b0};
    end
    r.rem = r2[31:0];
    r.lo  = {s.lo[30:0], 1'b0};
    return r;
  endfunction

  // signed saturation of a magnitude quotient
  function automatic logic [31:0] sat_comp(input logic neg, input logic ovf,
                                           input logic [31:0] q);
    logic [31:0] r;
    if (neg) begin
      if (ovf || (q > NEG_MAX)) r = NEG_MAX;
      else                      r = 32'd0 - q;
    end else begin
      if (ovf || q[31]) r = POS_MAX;
      else              r = q;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/vrl_fifo.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// vrl_fifo
// short job queue between the length front end and the rescale back end
// ---------------------------------------------------------------------------
module vrl_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire vrl_pkg::job_t wr_job,
  input  wire logic          pop,
  output vrl_pkg::job_t      rd_job,
  output logic               full,
  output logic               empty
);
  import vrl_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt;
  logic [Q_AW-1:0] rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full   = (cnt_r == Q_AW'(0) + (Q_AW+1)'(Q_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= wr_job;
  end

endmodule
`default_nettype wire

[hdl/vrl_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// vrl_front
// squares, sums and takes the root, then classifies the item for rescale
// ---------------------------------------------------------------------------
module vrl_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire vrl_pkg::item_t in_item,
  input  wire logic [15:0]    near_zero,
  output logic                job_valid,
  output vrl_pkg::job_t       job,
  input  wire logic           q_full
);
  import vrl_pkg::*;

  logic        en;
  logic        a_v_r, b_v_r, c_v_r;
  item_t       a_it_r, b_it_r, c_it_r;
  logic [31:0] a_ax_r, a_ay_r;
  logic [63:0] b_sx_r, b_sy_r;
  logic [63:0] c_sum_r;
  logic        s_v_r  [SQ_STAGES];
  item_t       s_it_r [SQ_STAGES];
  sq_t         s_r    [SQ_STAGES];
  sq_t         s_init;
  item_t       last;
  logic [31:0] len;

  // whole pipe holds while the queue refuses the last stage
  assign en       = !s_v_r[SQ_STAGES-1] || !q_full;
  assign in_ready = en;

  assign s_init = '{v: c_sum_r, rem: '0, root: '0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      for (int i = 0; i < SQ_STAGES; i++) s_v_r[i] <= 1'b0;
    end else if (en) begin
      a_v_r    <= in_valid;
      b_v_r    <= a_v_r;
      c_v_r    <= b_v_r;
      s_v_r[0] <= c_v_r;
      for (int i = 1; i < SQ_STAGES; i++) s_v_r[i] <= s_v_r[i-1];
    end
    if (en) begin
      a_it_r    <= in_item;
      a_ax_r    <= mag32(in_item.x);
      a_ay_r    <= mag32(in_item.y);
      b_it_r    <= a_it_r;
      b_sx_r    <= a_ax_r * a_ax_r;
      b_sy_r    <= a_ay_r * a_ay_r;
      c_it_r    <= b_it_r;
      c_sum_r   <= b_sx_r + b_sy_r;
      s_it_r[0] <= c_it_r;
      s_r[0]    <= sq_step(s_init);
      for (int i = 1; i < SQ_STAGES; i++) begin
        s_it_r[i] <= s_it_r[i-1];
        s_r[i]    <= sq_step(s_r[i-1]);
      end
    end
  end

  // classification
  always_comb begin
    last      = s_it_r[SQ_STAGES-1];
    len       = s_r[SQ_STAGES-1].root;
    job.x     = last.x;
    job.y     = last.y;
    job.tgt   = last.tgt;
    job.len   = len;
    job.scale = last.op && (last.tgt > {15'd0, near_zero})
                        && (len > {16'd0, near_zero});
    job.ok    = !last.op || job.scale;
  end

  assign job_valid = s_v_r[SQ_STAGES-1];

endmodule
`default_nettype wire

[hdl/vrl_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// vrl_back
// multiplies by the target, divides by the length, saturates scaled jobs (others pass x and y), output register
// ---------------------------------------------------------------------------
module vrl_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire vrl_pkg::job_t q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        x_out,
  output logic [31:0]        y_out,
  output logic [31:0]        len_out,
  output logic               ok_out
);
  import vrl_pkg::*;

  logic        en;
  logic        m_v_r;
  job_t        m_job_r;
  logic [63:0] m_px_r, m_py_r;
  logic        d_v_r   [DIV_STAGES];
  job_t        d_job_r [DIV_STAGES];
  dv_t         dx_r    [DIV_STAGES];
  dv_t         dy_r    [DIV_STAGES];
  logic        ox_r    [DIV_STAGES];
  logic        oy_r    [DIV_STAGES];
  dv_t         x_init, y_init;
  logic        o_v_r;
  logic [31:0] o_x_r, o_y_r, o_len_r;
  logic        o_ok_r;
  job_t        dl;

  assign en    = !o_v_r || out_ready;
  assign q_pop = en && q_valid;

  assign x_init = '{lo: m_px_r[31:0], rem: {1'b0, m_px_r[62:32]}, q: '0};
  assign y_init = '{lo: m_py_r[31:0], rem: {1'b0, m_py_r[62:32]}, q: '0};
  assign dl     = d_job_r[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      o_v_r <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) d_v_r[i] <= 1'b0;
    end else if (en) begin
      m_v_r    <= q_valid;
      d_v_r[0] <= m_v_r;
      for (int i = 1; i < DIV_STAGES; i++) d_v_r[i] <= d_v_r[i-1];
      o_v_r    <= d_v_r[DIV_STAGES-1];
    end
    if (en) begin
      m_job_r    <= q_job;
      m_px_r     <= mag32(q_job.x) * {1'b0, q_job.tgt};
      m_py_r     <= mag32(q_job.y) * {1'b0, q_job.tgt};
      d_job_r[0] <= m_job_r;
      dx_r[0]    <= dv_step(x_init, m_job_r.len);
      dy_r[0]    <= dv_step(y_init, m_job_r.len);
      ox_r[0]    <= ({1'b0, m_px_r[62:32]} >= m_job_r.len);
      oy_r[0]    <= ({1'b0, m_py_r[62:32]} >= m_job_r.len);
      for (int i = 1; i < DIV_STAGES; i++) begin
        d_job_r[i] <= d_job_r[i-1];
        dx_r[i]    <= dv_step(dx_r[i-1], d_job_r[i-1].len);
        dy_r[i]    <= dv_step(dy_r[i-1], d_job_r[i-1].len);
        ox_r[i]    <= ox_r[i-1];
        oy_r[i]    <= oy_r[i-1];
      end
      o_x_r   <= dl.scale ? sat_comp(dl.x[31], ox_r[DIV_STAGES-1], dx_r[DIV_STAGES-1].q)
                          : dl.x;
      o_y_r   <= dl.scale ? sat_comp(dl.y[31], oy_r[DIV_STAGES-1], dy_r[DIV_STAGES-1].q)
                          : dl.y;
      o_len_r <= dl.len;
      o_ok_r  <= dl.ok;
    end
  end

  assign out_valid = o_v_r;
  assign x_out     = o_x_r;
  assign y_out     = o_y_r;
  assign len_out   = o_len_r;
  assign ok_out    = o_ok_r;

endmodule
`default_nettype wire

[hdl/vector_rescale_to_length_core.sv]
// stages: abs, square and sum registers and one root bit per stage in the front,
//   the queue write, then multiply, one quotient bit per stage and saturate into
//   the output register in the back; the back holds while out_tready is low
// throughput: one beat per cycle unless held, from the fully staged root and divide pipes
// reset: synchronous active-low rst_n empties all stages and the queue and sets
//   near_zero to 16
`default_nettype none
// ---------------------------------------------------------------------------
// vector_rescale_to_length_core
// 2d vector length and rescale to a target length, streaming in and out
// ---------------------------------------------------------------------------
module vector_rescale_to_length_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // x_in[31:0], y_in[63:32], target_length[94:64], pad
  input  wire logic        in_tuser,   // op
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // x_out[31:0], y_out[63:32], length_out[95:64]
  output logic             out_tuser,  // ok
  // near_zero register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import vrl_pkg::*;

  logic [15:0] near_zero_r;
  item_t       in_item;
  logic        job_valid, q_full, q_empty, q_pop, q_push;
  job_t        f_job, q_job;
  logic [31:0] x_o, y_o, len_o;
  logic        ok_o;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_zero_r <= NEAR_ZERO_RST;
    end else if (cfg_valid) begin
      near_zero_r <= cfg_data;
    end
  end

  assign in_item = '{op: in_tuser, x: in_tdata[31:0], y: in_tdata[63:32],
                     tgt: in_tdata[94:64]};

  // front: length and classification
  vrl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .near_zero (near_zero_r),
    .job_valid (job_valid),
    .job       (f_job),
    .q_full    (q_full)
  );

  // last front stage moves into the queue when there is room
  assign q_push = job_valid && !q_full;

  vrl_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (f_job),
    .pop    (q_pop),
    .rd_job (q_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  // back: rescale and output register
  vrl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .x_out     (x_o),
    .y_out     (y_o),
    .len_out   (len_o),
    .ok_out    (ok_o)
  );

  assign out_tdata = {len_o, y_o, x_o};
  assign out_tuser = ok_o;

endmodule
`default_nettype wire
